/* src/eqre_pkg.sv */
// ----------------------------------------------------------------------------
// eqre_pkg: shared types and tables for the EPS QoS rate encoder
// Transaction payload structs, rate region codes and the per-region
// description of the arithmetic that turns a bit rate into an octet code.
// ----------------------------------------------------------------------------
package eqre_pkg;

	// Input transaction: one bit rate and the element boundary mark
	typedef struct packed {
		logic [39:0] rate_bps;
		logic        group_end;
	} eqre_item_t;

	// Output transaction: encoded octets, octet count and element length
	typedef struct packed {
		logic [7:0] rate_octet;
		logic [7:0] extended_octet;
		logic [7:0] extended2_octet;
		logic [1:0] octets_used;
		logic [3:0] ie_length;
	} eqre_result_t;

	// Rate regions in ascending order (B = base, E = extended, X = extended-2)
	typedef enum logic [4:0] {
		RG_ZERO,
		RG_B_1K,
		RG_B_8K,
		RG_B_GAP_LO,
		RG_B_64K,
		RG_B_GAP_HI,
		RG_E_100K,
		RG_E_GAP_LO,
		RG_E_1M,
		RG_E_GAP_MID,
		RG_E_2M,
		RG_E_GAP_HI,
		RG_X_4M,
		RG_X_GAP_LO,
		RG_X_10M,
		RG_X_GAP_MID,
		RG_X_100M,
		RG_X_SAT
	} region_t;

	// Inclusive upper limits in bit/s of each region (kbit/s = bps / 1000)
	localparam logic [39:0] LIM_ZERO      = 40'd999;
	localparam logic [39:0] LIM_B_1K      = 40'd63999;
	localparam logic [39:0] LIM_B_8K      = 40'd568999;
	localparam logic [39:0] LIM_B_GAP_LO  = 40'd575999;
	localparam logic [39:0] LIM_B_64K     = 40'd8640999;
	localparam logic [39:0] LIM_B_GAP_HI  = 40'd8699999;
	localparam logic [39:0] LIM_E_100K    = 40'd16000999;
	localparam logic [39:0] LIM_E_GAP_LO  = 40'd16999999;
	localparam logic [39:0] LIM_E_1M      = 40'd128000999;
	localparam logic [39:0] LIM_E_GAP_MID = 40'd129999999;
	localparam logic [39:0] LIM_E_2M      = 40'd256000999;
	localparam logic [39:0] LIM_E_GAP_HI  = 40'd259999999;
	localparam logic [39:0] LIM_X_4M      = 40'd500000999;
	localparam logic [39:0] LIM_X_GAP_LO  = 40'd509999999;
	localparam logic [39:0] LIM_X_10M     = 40'd1500000999;
	localparam logic [39:0] LIM_X_GAP_MID = 40'd1599999999;
	localparam logic [39:0] LIM_X_100M    = 40'd10000000999;

	// Fixed octet codes
	localparam logic [7:0] OCT_BASE_FULL = 8'hFE;
	localparam logic [7:0] OCT_EXT_FULL  = 8'hFA;

	// Step division: q = (((rate - base) >> pre_shift) * recip) >> post_shift
	// recip = ceil(2^post_shift / odd part of the step), exact over the region.
	typedef struct packed {
		logic [1:0]  used;
		logic        calc;
		logic [30:0] base;
		logic [3:0]  pre_shift;
		logic [25:0] recip;
		logic [5:0]  post_shift;
		logic [7:0]  value;
	} region_desc_t;

	typedef struct packed {
		logic [1:0] used;
		logic [7:0] code;
	} eqre_code_t;

	function automatic region_desc_t mk_desc(input logic [1:0] used, input logic calc,
			input logic [30:0] base, input logic [3:0] pre_shift, input logic [25:0] recip,
			input logic [5:0] post_shift, input logic [7:0] value);
		region_desc_t d;
		d.used       = used;
		d.calc       = calc;
		d.base       = base;
		d.pre_shift  = pre_shift;
		d.recip      = recip;
		d.post_shift = post_shift;
		d.value      = value;
		return d;
	endfunction

	function automatic region_desc_t region_desc(input region_t rg);
		region_desc_t d;
		unique case (rg)
			RG_ZERO:       d = mk_desc(2'd0, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'h00);
			// 1 kbit/s steps from 0
			RG_B_1K:       d = mk_desc(2'd1, 1'b1, 31'd0, 4'd3, 26'd8389, 6'd20, 8'h00);
			// 8 kbit/s steps from 64 kbit/s
			RG_B_8K:       d = mk_desc(2'd1, 1'b1, 31'd64000, 4'd6, 26'd8389, 6'd20, 8'h40);
			RG_B_GAP_LO:   d = mk_desc(2'd1, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'h7F);
			// 64 kbit/s steps from 576 kbit/s
			RG_B_64K:      d = mk_desc(2'd1, 1'b1, 31'd576000, 4'd9, 26'd16778, 6'd21, 8'h80);
			RG_B_GAP_HI:   d = mk_desc(2'd1, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, OCT_BASE_FULL);
			// 100 kbit/s steps from 8600 kbit/s
			RG_E_100K:     d = mk_desc(2'd2, 1'b1, 31'd8600000, 4'd5, 26'd343598, 6'd30,
				8'h00);
			RG_E_GAP_LO:   d = mk_desc(2'd2, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'h4A);
			// 1 Mbit/s steps from 16 Mbit/s
			RG_E_1M:       d = mk_desc(2'd2, 1'b1, 31'd16000000, 4'd6, 26'd2199024, 6'd35,
				8'h4A);
			RG_E_GAP_MID:  d = mk_desc(2'd2, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'hBA);
			// 2 Mbit/s steps from 128 Mbit/s
			RG_E_2M:       d = mk_desc(2'd2, 1'b1, 31'd128000000, 4'd7, 26'd1099512, 6'd34,
				8'hBA);
			RG_E_GAP_HI:   d = mk_desc(2'd2, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, OCT_EXT_FULL);
			// 4 Mbit/s steps from 256 Mbit/s
			RG_X_4M:       d = mk_desc(2'd3, 1'b1, 31'd256000000, 4'd8, 26'd1099512, 6'd34,
				8'h00);
			RG_X_GAP_LO:   d = mk_desc(2'd3, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'h3D);
			// 10 Mbit/s steps from 500 Mbit/s
			RG_X_10M:      d = mk_desc(2'd3, 1'b1, 31'd500000000, 4'd7, 26'd14073749, 6'd40,
				8'h3D);
			RG_X_GAP_MID:  d = mk_desc(2'd3, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'hA1);
			// 100 Mbit/s steps from 1500 Mbit/s
			RG_X_100M:     d = mk_desc(2'd3, 1'b1, 31'd1500000000, 4'd8, 26'd45035997, 6'd44,
				8'hA1);
			RG_X_SAT:      d = mk_desc(2'd3, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'hF6);
			default:       d = mk_desc(2'd0, 1'b0, 31'd0, 4'd0, 26'd0, 6'd0, 8'h00);
		endcase
		return d;
	endfunction

endpackage

/* src/eps_qos_rate_encoder.sv */
// ----------------------------------------------------------------------------
// eps_qos_rate_encoder: EPS QoS bit rate encoder
// Converts bit rates to base, extended and extended-2 rate octets and
// tracks the element length across a group of rates.
// ----------------------------------------------------------------------------
// Each transaction is one rate in bit/s; it is taken into the input register
// at the accepting edge and its result moves into the result register when
// that register is free. A new transaction is taken every cycle while
// item_stall is low, one result per item. The rate is matched against fixed
// region limits and divided by the region step through one reciprocal
// multiplier in the single stage between the two registers. Rates below
// 1000 bit/s give all-zero octets and leave the element length unchanged.
// ie_length is the largest octet count since the last group_end item, this
// item included, times 4 plus 1; the count restarts after a group_end item.
// Stall on the result side backs up into item_stall only when both
// registers hold transactions.
module eps_qos_rate_encoder import eqre_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  eqre_item_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output eqre_result_t result
);

	eqre_item_t   item_s1;
	logic         valid_s1;
	eqre_result_t result_s2;
	logic         valid_s2;
	logic [1:0]   max_q;

	logic         s2_free;
	logic         s1_move;
	logic         s1_free;
	region_t      region;
	eqre_code_t   code;
	logic [1:0]   max_new;
	eqre_result_t result_nxt;

	// Pipeline flow control
	assign s2_free    = ~valid_s2 | ~result_stall;
	assign s1_move    = valid_s1 & s2_free;
	assign s1_free    = ~valid_s1 | s2_free;
	assign item_stall = ~s1_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_valid) begin
			item_s1 <= item;
		end
	end

	// Region decode and step division
	eqre_classify u_classify (
		.rate_bps (item_s1.rate_bps),
		.region   (region)
	);

	eqre_quant u_quant (
		.rate_bps (item_s1.rate_bps),
		.region   (region),
		.result   (code)
	);

	// Running maximum of octets used in the current element
	assign max_new = (code.used > max_q) ? code.used : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 2'd0;
		end else if (s1_move) begin
			max_q <= item_s1.group_end ? 2'd0 : max_new;
		end
	end

	// Octet placement by count used
	always_comb begin
		result_nxt.octets_used = code.used;
		result_nxt.ie_length   = {max_new, 2'b01};
		case (code.used)
			2'd1: begin
				result_nxt.rate_octet      = code.code;
				result_nxt.extended_octet  = 8'd0;
				result_nxt.extended2_octet = 8'd0;
			end
			2'd2: begin
				result_nxt.rate_octet      = OCT_BASE_FULL;
				result_nxt.extended_octet  = code.code;
				result_nxt.extended2_octet = 8'd0;
			end
			2'd3: begin
				result_nxt.rate_octet      = OCT_BASE_FULL;
				result_nxt.extended_octet  = OCT_EXT_FULL;
				result_nxt.extended2_octet = code.code;
			end
			default: begin
				result_nxt.rate_octet      = 8'd0;
				result_nxt.extended_octet  = 8'd0;
				result_nxt.extended2_octet = 8'd0;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2 <= result_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

/* src/eqre_classify.sv */
// ----------------------------------------------------------------------------
// eqre_classify: rate region decoder
// Compares the bit rate against the fixed region limits and returns the
// region that selects the step, base and octet of the encoding.
// ----------------------------------------------------------------------------
module eqre_classify import eqre_pkg::*; (
	input  logic [39:0] rate_bps,
	output region_t     region
);

	// Priority chain over ascending limits
	always_comb begin
		if (rate_bps <= LIM_ZERO)           region = RG_ZERO;
		else if (rate_bps <= LIM_B_1K)      region = RG_B_1K;
		else if (rate_bps <= LIM_B_8K)      region = RG_B_8K;
		else if (rate_bps <= LIM_B_GAP_LO)  region = RG_B_GAP_LO;
		else if (rate_bps <= LIM_B_64K)     region = RG_B_64K;
		else if (rate_bps <= LIM_B_GAP_HI)  region = RG_B_GAP_HI;
		else if (rate_bps <= LIM_E_100K)    region = RG_E_100K;
		else if (rate_bps <= LIM_E_GAP_LO)  region = RG_E_GAP_LO;
		else if (rate_bps <= LIM_E_1M)      region = RG_E_1M;
		else if (rate_bps <= LIM_E_GAP_MID) region = RG_E_GAP_MID;
		else if (rate_bps <= LIM_E_2M)      region = RG_E_2M;
		else if (rate_bps <= LIM_E_GAP_HI)  region = RG_E_GAP_HI;
		else if (rate_bps <= LIM_X_4M)      region = RG_X_4M;
		else if (rate_bps <= LIM_X_GAP_LO)  region = RG_X_GAP_LO;
		else if (rate_bps <= LIM_X_10M)     region = RG_X_10M;
		else if (rate_bps <= LIM_X_GAP_MID) region = RG_X_GAP_MID;
		else if (rate_bps <= LIM_X_100M)    region = RG_X_100M;
		else                                region = RG_X_SAT;
	end

endmodule

/* src/eqre_quant.sv */
// ----------------------------------------------------------------------------
// eqre_quant: step quantizer
// Subtracts the region base, divides by the region step with one shared
// reciprocal multiplier and adds the region code offset.
// ----------------------------------------------------------------------------
module eqre_quant import eqre_pkg::*; (
	input  logic [39:0] rate_bps,
	input  region_t     region,
	output eqre_code_t  result
);

	region_desc_t desc;
	logic [39:0]  diff;
	logic [24:0]  scaled;
	logic [50:0]  prod;
	logic [6:0]   quot;

	assign desc = region_desc(region);

	// Offset into the region, power-of-two part of the step removed
	assign diff   = rate_bps - {9'd0, desc.base};
	assign scaled = 25'(diff >> desc.pre_shift);

	// Odd part of the step by reciprocal multiply
	assign prod = 51'(scaled) * 51'(desc.recip);
	assign quot = 7'(prod >> desc.post_shift);

	// Gap and saturation regions carry a fixed code
	assign result = {desc.used, desc.value + (desc.calc ? {1'b0, quot} : 8'd0)};

endmodule
